/* hdl/http_date_parser_macros.svh */
// Assertion macros for the HTTP date parser.
// Used by hdp_seq under hdl; no other dependencies.
// Defining ASSERT_OFF removes every assertion built from these macros.
`ifndef HTTP_DATE_PARSER_MACROS_SVH
`define HTTP_DATE_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising clock edge except while reset is high.
`define HDP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define HDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HDP_ASSERT(lbl, clk, rst, prop, msg)
`define HDP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hdl/hdp_pkg.sv */
// Shared types, constants and small functions of the HTTP date parser.
// No dependencies; imported by every module of the block but hdp_mul.
`timescale 1ns / 1ps

package hdp_pkg;

  localparam int unsigned DATE_LEN = 29;
  localparam int unsigned POS_W    = 5;

  // Byte positions inside the fixed-format date string.
  localparam logic [POS_W-1:0] POS_WDAY_END = 5'd3;
  localparam logic [POS_W-1:0] POS_DAY_HI   = 5'd5;
  localparam logic [POS_W-1:0] POS_DAY_LO   = 5'd6;
  localparam logic [POS_W-1:0] POS_MON_END  = 5'd11;
  localparam logic [POS_W-1:0] POS_YEAR_0   = 5'd12;
  localparam logic [POS_W-1:0] POS_YEAR_1   = 5'd13;
  localparam logic [POS_W-1:0] POS_YEAR_2   = 5'd14;
  localparam logic [POS_W-1:0] POS_YEAR_3   = 5'd15;
  localparam logic [POS_W-1:0] POS_HOUR_HI  = 5'd17;
  localparam logic [POS_W-1:0] POS_HOUR_LO  = 5'd18;
  localparam logic [POS_W-1:0] POS_MIN_HI   = 5'd20;
  localparam logic [POS_W-1:0] POS_MIN_LO   = 5'd21;
  localparam logic [POS_W-1:0] POS_SEC_HI   = 5'd23;
  localparam logic [POS_W-1:0] POS_SEC_LO   = 5'd24;
  localparam logic [POS_W-1:0] POS_ZONE_G   = 5'd26;
  localparam logic [POS_W-1:0] POS_ZONE_M   = 5'd27;
  localparam logic [POS_W-1:0] POS_ZONE_T   = 5'd28;
  localparam logic [POS_W-1:0] POS_END      = 5'd29;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_G    = 8'h47;
  localparam logic [7:0] CHAR_M    = 8'h4D;
  localparam logic [7:0] CHAR_T    = 8'h54;

  localparam logic [6:0]  DAY_MIN  = 7'd1;
  localparam logic [6:0]  DAY_MAX  = 7'd31;
  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [6:0]  HOUR_MAX = 7'd24;
  localparam logic [6:0]  MS_MAX   = 7'd60;

  localparam logic [31:0] WDAY_NAMES [7] = '{
    32'h53756E2C, 32'h4D6F6E2C, 32'h5475652C, 32'h5765642C,
    32'h5468752C, 32'h4672692C, 32'h5361742C
  };

  localparam logic [31:0] MONTH_NAMES [12] = '{
    32'h4A616E20, 32'h46656220, 32'h4D617220, 32'h41707220,
    32'h4D617920, 32'h4A756E20, 32'h4A756C20, 32'h41756720,
    32'h53657020, 32'h4F637420, 32'h4E6F7620, 32'h44656320
  };

  // Arithmetic constants of the epoch computation.
  localparam logic [16:0] DAYS_PER_YEAR = 17'd365;
  localparam logic [16:0] RECIP_100     = 17'd5243;  // floor(x/100) = x*5243 >> 19
  localparam int unsigned RECIP_SHIFT   = 19;
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [14:0] YEAR_SHIFT    = 15'd400;
  // Day count of 1970-01-01 in the shifted-year sum, plus one for the day base.
  localparam logic signed [39:0] DAY_BIAS = 40'sd865566;

  localparam logic signed [39:0] EPOCH_MIN = -40'sd62167219200;
  localparam logic signed [39:0] EPOCH_MAX = 40'sd253402304460;

  typedef struct packed {
    logic        start;
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month_idx;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } fields_t;

  typedef struct packed {
    logic        done;
    logic        ok;
    logic [38:0] epoch;
  } result_t;

  // One decimal digit appended to an accumulator, kept to 14 bits.
  function automatic logic [13:0] dec_step(input logic [13:0] acc, input logic [3:0] d);
    logic [17:0] t;
    t = {4'd0, acc} * 18'd10 + {14'd0, d};
    return t[13:0];
  endfunction

  // Day of the March-based year on which the given month (0 = January) starts.
  function automatic logic [8:0] month_doy(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd306;
      4'd1:    r = 9'd337;
      4'd2:    r = 9'd0;
      4'd3:    r = 9'd31;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd92;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd153;
      4'd8:    r = 9'd184;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd245;
      4'd11:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/hdp_front.sv */
// Byte-serial front end: checks each date byte against its position and
// collects the decimal fields. Depends on hdp_pkg.
`timescale 1ns / 1ps

module hdp_front import hdp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_byte,
  input  logic       last_byte,
  output fields_t    fields
);

  logic [POS_W-1:0] pos, pos_next;
  logic             overlength, overlength_next;
  logic             err, err_next;
  logic [31:0]      name_shift, name_shift_next;
  logic [3:0]       month_idx, month_idx_next;
  logic [6:0]       day, day_next;
  logic [13:0]      year, year_next;
  logic [6:0]       hour, hour_next;
  logic [6:0]       minute, minute_next;
  logic [6:0]       second, second_next;

  logic       is_digit;
  logic [3:0] digit;
  logic       wday_hit;
  logic       mon_hit;
  logic [3:0] mon_sel;

  assign is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
  assign digit    = char_byte[3:0];

  always_comb begin
    name_shift_next = {name_shift[23:0], char_byte};
    wday_hit = 1'b0;
    for (int i = 0; i < 7; i++) begin
      if (name_shift_next == WDAY_NAMES[i]) wday_hit = 1'b1;
    end
    mon_hit = 1'b0;
    mon_sel = month_idx;
    for (int i = 0; i < 12; i++) begin
      if (name_shift_next == MONTH_NAMES[i]) begin
        mon_hit = 1'b1;
        mon_sel = 4'(i);
      end
    end
  end

  always_comb begin
    pos_next        = pos;
    overlength_next = overlength;
    err_next        = err;
    month_idx_next  = month_idx;
    day_next        = day;
    year_next       = year;
    hour_next       = hour;
    minute_next     = minute;
    second_next     = second;
    if (pos >= POS_END) begin
      overlength_next = 1'b1;
    end else begin
      pos_next = pos + 5'd1;
      case (pos)
        POS_WDAY_END: begin
          if (!wday_hit) err_next = 1'b1;
        end
        POS_DAY_HI, POS_DAY_LO: begin
          if (is_digit) day_next = 7'(dec_step({7'd0, day}, digit));
          else err_next = 1'b1;
          if (pos == POS_DAY_LO && (day_next < DAY_MIN || day_next > DAY_MAX)) err_next = 1'b1;
        end
        POS_MON_END: begin
          if (mon_hit) month_idx_next = mon_sel;
          else err_next = 1'b1;
        end
        POS_YEAR_0, POS_YEAR_1, POS_YEAR_2, POS_YEAR_3: begin
          if (is_digit) year_next = dec_step(year, digit);
          else err_next = 1'b1;
          if (pos == POS_YEAR_3 && year_next > YEAR_MAX) err_next = 1'b1;
        end
        POS_HOUR_HI, POS_HOUR_LO: begin
          if (is_digit) hour_next = 7'(dec_step({7'd0, hour}, digit));
          else err_next = 1'b1;
          if (pos == POS_HOUR_LO && hour_next > HOUR_MAX) err_next = 1'b1;
        end
        POS_MIN_HI, POS_MIN_LO: begin
          if (is_digit) minute_next = 7'(dec_step({7'd0, minute}, digit));
          else err_next = 1'b1;
          if (pos == POS_MIN_LO && minute_next > MS_MAX) err_next = 1'b1;
        end
        POS_SEC_HI, POS_SEC_LO: begin
          if (is_digit) second_next = 7'(dec_step({7'd0, second}, digit));
          else err_next = 1'b1;
          if (pos == POS_SEC_LO && second_next > MS_MAX) err_next = 1'b1;
        end
        POS_ZONE_G: begin
          if (char_byte != CHAR_G) err_next = 1'b1;
        end
        POS_ZONE_M: begin
          if (char_byte != CHAR_M) err_next = 1'b1;
        end
        POS_ZONE_T: begin
          if (char_byte != CHAR_T) err_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // The fields of a complete string are final before its zone letters arrive,
  // so the sequencer can take the current registers on the last byte.
  always_comb begin
    fields.start     = accept && last_byte;
    fields.ok        = (pos == POS_ZONE_T) && !err_next;
    fields.year      = year;
    fields.month_idx = month_idx;
    fields.day       = day;
    fields.hour      = hour;
    fields.minute    = minute;
    fields.second    = second;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      pos        <= '0;
      overlength <= 1'b0;
      err        <= 1'b0;
      name_shift <= '0;
      month_idx  <= '0;
      day        <= '0;
      year       <= '0;
      hour       <= '0;
      minute     <= '0;
      second     <= '0;
    end else if (accept) begin
      pos        <= pos_next;
      overlength <= overlength_next;
      err        <= err_next;
      name_shift <= name_shift_next;
      month_idx  <= month_idx_next;
      day        <= day_next;
      year       <= year_next;
      hour       <= hour_next;
      minute     <= minute_next;
      second     <= second_next;
    end
  end

endmodule

/* hdl/hdp_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module hdp_mul (
  input  logic               clk,
  input  logic signed [23:0] a,
  input  logic        [16:0] b,
  output logic signed [39:0] prod
);

  logic signed [41:0] full;

  assign full = a * $signed({1'b0, b});

  always_ff @(posedge clk) begin
    prod <= full[39:0];
  end

endmodule

/* hdl/hdp_seq.sv */
// Epoch sequencer: drives the shared multiplier step by step and sums the
// terms of the day and second count. Depends on hdp_pkg, hdp_mul and the macros.
`timescale 1ns / 1ps
`include "http_date_parser_macros.svh"

module hdp_seq import hdp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  fields_t fields,
  input  logic    take,
  output result_t res,
  output logic    busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_YEAR, S_C100, S_C400, S_DAYS, S_SCALE, S_SECS, S_HOUR, S_MIN, S_HOLD
  } state_t;

  state_t             state;
  logic               ok;
  logic signed [39:0] acc;
  logic [13:0]        yadj;
  logic [6:0]         hour;
  logic [6:0]         minute;
  logic [6:0]         fields_sec;

  logic [14:0]        y_wide;
  logic signed [39:0] base;
  logic signed [23:0] mul_a;
  logic [16:0]        mul_b;
  logic signed [39:0] prod;
  logic signed [39:0] quot;

  // Shifting the year by 400 keeps it non-negative; January and February
  // count as the end of the previous year.
  assign y_wide = {1'b0, fields.year} + YEAR_SHIFT - {14'd0, (fields.month_idx < 4'd2)};
  assign base   = $signed({33'd0, fields.day}) + $signed({31'd0, month_doy(fields.month_idx)})
                + $signed({28'd0, y_wide[13:2]}) - DAY_BIAS;
  assign quot   = $signed({19'd0, prod[39:RECIP_SHIFT]});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_YEAR: begin
        mul_a = $signed({10'd0, yadj});
        mul_b = DAYS_PER_YEAR;
      end
      S_C100: begin
        mul_a = $signed({10'd0, yadj});
        mul_b = RECIP_100;
      end
      S_C400: begin
        mul_a = $signed({12'd0, yadj[13:2]});
        mul_b = RECIP_100;
      end
      S_SCALE: begin
        mul_a = acc[23:0];
        mul_b = SECS_PER_DAY;
      end
      S_SECS: begin
        mul_a = $signed({17'd0, hour});
        mul_b = SECS_PER_HOUR;
      end
      S_HOUR: begin
        mul_a = $signed({17'd0, minute});
        mul_b = SECS_PER_MIN;
      end
      default: begin
      end
    endcase
  end

  hdp_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ok    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (fields.start) begin
            ok     <= fields.ok;
            acc    <= base;
            yadj   <= y_wide[13:0];
            hour   <= fields.hour;
            minute <= fields.minute;
            state  <= fields.ok ? S_YEAR : S_HOLD;
          end
        end
        S_YEAR: state <= S_C100;
        S_C100: begin
          acc   <= acc + prod;
          state <= S_C400;
        end
        S_C400: begin
          acc   <= acc - quot;
          state <= S_DAYS;
        end
        S_DAYS: begin
          acc   <= acc + quot;
          state <= S_SCALE;
        end
        S_SCALE: state <= S_SECS;
        S_SECS: begin
          acc   <= prod + $signed({33'd0, fields_sec});
          state <= S_HOUR;
        end
        S_HOUR: begin
          acc   <= acc + prod;
          state <= S_MIN;
        end
        S_MIN: begin
          acc   <= acc + prod;
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The seconds field is kept from the start of the transaction.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && fields.start) fields_sec <= fields.second;
  end

  assign busy      = (state != S_IDLE);
  assign res.done  = (state == S_HOLD);
  assign res.ok    = ok;
  assign res.epoch = ok ? acc[38:0] : '0;

  `HDP_ASSERT(a_start_idle, clk, rst, fields.start |-> state == S_IDLE, "string ended while busy")
  `HDP_ASSERT(a_epoch_range, clk, rst,
    (state == S_HOLD && ok) |-> (acc >= EPOCH_MIN && acc <= EPOCH_MAX),
    "epoch out of range")
  `HDP_ASSERT(a_reject_fast, clk, rst,
    (state == S_IDLE && fields.start && !fields.ok) |=> state == S_HOLD && !ok,
    "rejected string not reported at once")

endmodule

/* hdl/http_date_parser.sv */
// Top level of the HTTP date parser: stream ports, front end, epoch sequencer
// and the output register. Depends on hdp_pkg, hdp_front and hdp_seq.
//
//   channel   direction  payload
//   s_axis    in         tdata: char_byte[7:0]; tlast: last_byte
//   m_axis    out        tdata: epoch_seconds[38:0], zero pad; tuser: valid_res
//
// Date bytes are taken one per cycle while the sequencer is idle.
// A final byte of a rejected string sends the sequencer straight to its hold state;
// a valid one first passes eight sequencer steps; the output register loads either when free.
// s_axis_tready is low from a final byte until its result is in the output register.
// rst is synchronous and clears all control state; a stalled result holds.
`timescale 1ns / 1ps

module http_date_parser import hdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
  output logic        m_axis_tuser    // [0] valid_res
);

  fields_t fields;
  result_t res;
  logic    busy;
  logic    accept;
  logic    load;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load          = res.done && (!m_axis_tvalid || m_axis_tready);

  hdp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_byte (s_axis_tdata),
    .last_byte (s_axis_tlast),
    .fields    (fields)
  );

  hdp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .fields (fields),
    .take   (load),
    .res    (res),
    .busy   (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {1'b0, res.epoch};
      m_axis_tuser <= res.ok;
    end
  end

endmodule

/* bench/hdp_epoch_checker.sv */
// Checker for the HTTP date parser: follows every date byte taken on s_axis,
// predicts the verdict and epoch seconds, and compares each m_axis transaction.
// Depends on hdp_pkg for byte positions, characters and name tables.
`timescale 1ns / 1ps

module hdp_epoch_checker import hdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
  input  logic        m_axis_tuser,   // [0] valid_res
  output int          error_count,
  output int          pending
);

  typedef struct packed {
    logic        ok;
    logic [38:0] secs;
  } epoch_rec_t;

  epoch_rec_t expected_epochs [$];
  epoch_rec_t oldest;

  // Parser state as the block should hold it.
  logic [4:0]  pos;
  logic        over;
  logic        err;
  logic [31:0] last_four;
  logic [3:0]  mon;
  logic [6:0]  day;
  logic [13:0] year;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [6:0]  second;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < 50)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic clear_date_state();
    pos       = '0;
    over      = 1'b0;
    err       = 1'b0;
    last_four = '0;
    mon       = '0;
    day       = '0;
    year      = '0;
    hour      = '0;
    minute    = '0;
    second    = '0;
  endtask

  // Seconds since 1970-01-01 for a day counted from the first of the month,
  // so out-of-range days, hours, minutes and seconds carry over naturally.
  function automatic logic [38:0] civil_epoch(input logic [13:0] yr,
                                              input logic [3:0] mi_idx,
                                              input logic [6:0] dd, input logic [6:0] hh,
                                              input logic [6:0] mm, input logic [6:0] ss);
    longint y, m, era, yoe, doy, doe, days, secs;
    y = longint'(yr);
    m = longint'(mi_idx) + 1;
    if (m <= 2)
      y = y - 1;
    era  = (y >= 0 ? y : y - 399) / 400;
    yoe  = y - era * 400;
    doy  = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468 + longint'(dd) - 1;
    secs = days * 86400 + longint'(hh) * 3600 + longint'(mm) * 60 + longint'(ss);
    return secs[38:0];
  endfunction

  task automatic take_date_byte(input logic [7:0] c, input logic fin);
    logic [4:0] p;
    logic       hit;
    logic       digit;
    epoch_rec_t rec;
    p         = pos;
    last_four = {last_four[23:0], c};
    digit     = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    if (p >= POS_END) begin
      over = 1'b1;
    end else begin
      case (p)
        POS_WDAY_END: begin
          hit = 1'b0;
          for (int i = 0; i < 7; i++)
            if (last_four == WDAY_NAMES[i]) hit = 1'b1;
          if (!hit) err = 1'b1;
        end
        POS_DAY_HI, POS_DAY_LO: begin
          if (!digit) err = 1'b1;
          else day = 7'(day * 10 + (c - CHAR_ZERO));
          if (p == POS_DAY_LO && (day < DAY_MIN || day > DAY_MAX)) err = 1'b1;
        end
        POS_MON_END: begin
          hit = 1'b0;
          for (int i = 0; i < 12; i++)
            if (last_four == MONTH_NAMES[i]) begin
              hit = 1'b1;
              mon = 4'(i);
            end
          if (!hit) err = 1'b1;
        end
        POS_YEAR_0, POS_YEAR_1, POS_YEAR_2, POS_YEAR_3: begin
          if (!digit) err = 1'b1;
          else year = 14'(year * 10 + (c - CHAR_ZERO));
          if (p == POS_YEAR_3 && year > YEAR_MAX) err = 1'b1;
        end
        POS_HOUR_HI, POS_HOUR_LO: begin
          if (!digit) err = 1'b1;
          else hour = 7'(hour * 10 + (c - CHAR_ZERO));
          if (p == POS_HOUR_LO && hour > HOUR_MAX) err = 1'b1;
        end
        POS_MIN_HI, POS_MIN_LO: begin
          if (!digit) err = 1'b1;
          else minute = 7'(minute * 10 + (c - CHAR_ZERO));
          if (p == POS_MIN_LO && minute > MS_MAX) err = 1'b1;
        end
        POS_SEC_HI, POS_SEC_LO: begin
          if (!digit) err = 1'b1;
          else second = 7'(second * 10 + (c - CHAR_ZERO));
          if (p == POS_SEC_LO && second > MS_MAX) err = 1'b1;
        end
        POS_ZONE_G: if (c != CHAR_G) err = 1'b1;
        POS_ZONE_M: if (c != CHAR_M) err = 1'b1;
        POS_ZONE_T: if (c != CHAR_T) err = 1'b1;
        default: ;
      endcase
      pos = p + 5'd1;
    end
    if (fin) begin
      if (!over && p == POS_ZONE_T && !err) begin
        rec.ok   = 1'b1;
        rec.secs = civil_epoch(year, mon, day, hour, minute, second);
      end else begin
        rec.ok   = 1'b0;
        rec.secs = '0;
      end
      expected_epochs.push_back(rec);
      clear_date_state();
    end
  endtask

  initial begin
    error_count = 0;
    pending     = 0;
    clear_date_state();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_date_state();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_epochs.size() == 0) begin
          report_mismatch("result with none expected", {24'd0, m_axis_tdata}, '0);
        end else begin
          oldest = expected_epochs.pop_front();
          if (m_axis_tuser !== oldest.ok)
            report_mismatch("valid flag", 64'(m_axis_tuser), 64'(oldest.ok));
          if (m_axis_tdata[38:0] !== oldest.secs)
            report_mismatch("epoch seconds", 64'(m_axis_tdata[38:0]), 64'(oldest.secs));
          if (m_axis_tdata[39] !== 1'b0)
            report_mismatch("tdata pad bit", 64'(m_axis_tdata[39]), '0);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        take_date_byte(s_axis_tdata, s_axis_tlast);
      pending = expected_epochs.size();
    end
  end

endmodule

/* bench/tb.sv */
// Testbench top for the HTTP date parser: clock, reset, date strings on s_axis,
// random back-pressure on m_axis, and the final verdict.
// Depends on hdp_pkg, http_date_parser and hdp_epoch_checker.
`timescale 1ns / 1ps

module tb import hdp_pkg::*; ();

  localparam int CLK_HALF     = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 800;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_LOW_S = 8'h73;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  int error_count;
  int pending;
  int send_idle;
  int recv_idle;
  int hold_seq;
  int hold_done;

  logic [7:0] line_buf [64];
  int         line_len;

  http_date_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  hdp_epoch_checker i_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .error_count   (error_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_seq moves.
  initial begin
    m_axis_tready = 1'b0;
    hold_done     = 0;
    forever begin
      @(negedge clk);
      if (hold_done != hold_seq) begin
        hold_done = hold_seq;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic put_two(input int at, input int v);
    line_buf[at]     = 8'(CHAR_ZERO + v / 10);
    line_buf[at + 1] = 8'(CHAR_ZERO + v % 10);
  endtask

  task automatic make_date(input int wd, input int dd, input int mo, input int yr,
                           input int hh, input int mm, input int ss);
    for (int i = 0; i < 4; i++) begin
      line_buf[i]     = WDAY_NAMES[wd][31 - 8 * i -: 8];
      line_buf[8 + i] = MONTH_NAMES[mo][31 - 8 * i -: 8];
    end
    line_buf[4] = CHAR_SPACE;
    put_two(5, dd);
    line_buf[7] = CHAR_SPACE;
    put_two(12, yr / 100);
    put_two(14, yr % 100);
    line_buf[16] = CHAR_SPACE;
    put_two(17, hh);
    line_buf[19] = CHAR_COLON;
    put_two(20, mm);
    line_buf[22] = CHAR_COLON;
    put_two(23, ss);
    line_buf[25] = CHAR_SPACE;
    line_buf[26] = CHAR_G;
    line_buf[27] = CHAR_M;
    line_buf[28] = CHAR_T;
    line_len = DATE_LEN;
  endtask

  task automatic fill_skipped(input logic [7:0] v, input bit rnd);
    line_buf[4]  = rnd ? 8'($urandom_range(255)) : v;
    line_buf[7]  = rnd ? 8'($urandom_range(255)) : v;
    line_buf[16] = rnd ? 8'($urandom_range(255)) : v;
    line_buf[19] = rnd ? 8'($urandom_range(255)) : v;
    line_buf[22] = rnd ? 8'($urandom_range(255)) : v;
    line_buf[25] = rnd ? 8'($urandom_range(255)) : v;
  endtask

  // Entered and left at a falling edge; each byte waits for its transaction.
  task automatic send_byte(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_len; i++)
      send_byte(line_buf[i], i == line_len - 1);
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic make_random_date();
    int yr;
    yr = $urandom_range(1) ? $urandom_range(9999) : $urandom_range(2100, 1900);
    make_date($urandom_range(6), $urandom_range(31, 1), $urandom_range(11), yr,
              $urandom_range(24), $urandom_range(60), $urandom_range(60));
    if ($urandom_range(3) == 0) fill_skipped(8'h00, 1'b1);
  endtask

  task automatic make_random_line();
    int r;
    int extra;
    r = $urandom_range(99);
    make_random_date();
    if (r < 62) begin
      // well-formed date with random content
    end else if (r < 70) begin
      make_date($urandom_range(6), $urandom_range(99), $urandom_range(11),
                $urandom_range(9999), $urandom_range(99), $urandom_range(99),
                $urandom_range(99));
    end else if (r < 80) begin
      line_buf[$urandom_range(28)] = 8'($urandom_range(255));
    end else if (r < 87) begin
      line_len = $urandom_range(28, 1);
    end else if (r < 93) begin
      extra = $urandom_range(8, 1);
      for (int i = 0; i < extra; i++) line_buf[DATE_LEN + i] = 8'($urandom_range(255));
      line_len = DATE_LEN + extra;
    end else begin
      line_len = $urandom_range(40, 1);
      for (int i = 0; i < line_len; i++) line_buf[i] = 8'($urandom_range(255));
    end
  endtask

  task automatic run_directed();
    make_date(0, 6, 10, 1994, 8, 49, 37);   send_line();
    make_date(6, 1, 0, 0, 0, 0, 0);         send_line();   // earliest date
    make_date(5, 31, 11, 9999, 24, 60, 60); send_line();   // latest with carries
    // Every month and weekday; February 31 carries into March.
    for (int m = 0; m < 12; m++) begin
      make_date(m % 7, (m == 1) ? 31 : 1 + 2 * m, m, 1970 + 37 * m, m, 5 * m, 59 - m);
      send_line();
    end
    make_date(3, 15, 6, 2024, 12, 30, 45); fill_skipped(8'hFF, 1'b0); send_line();
    make_date(4, 15, 6, 2024, 12, 30, 45); fill_skipped(8'h00, 1'b0); send_line();
    make_date(1, 15, 6, 2024, 12, 30, 45); line_buf[5] = CHAR_SLASH; send_line();
    make_date(1, 15, 6, 2024, 12, 30, 45); line_buf[24] = CHAR_COLON; send_line();
    make_date(2, 0, 2, 2000, 1, 1, 1);      send_line();
    make_date(2, 32, 2, 2000, 1, 1, 1);     send_line();
    make_date(2, 10, 2, 2000, 25, 1, 1);    send_line();
    make_date(2, 10, 2, 2000, 1, 61, 1);    send_line();
    make_date(2, 10, 2, 2000, 1, 1, 61);    send_line();
    make_date(0, 10, 2, 2000, 1, 1, 1); line_buf[0] = CHAR_LOW_S; send_line();
    make_date(0, 10, 2, 2000, 1, 1, 1); line_buf[10] = CHAR_X;    send_line();
    make_date(0, 10, 2, 2000, 1, 1, 1); line_buf[28] = CHAR_X;    send_line();
    make_date(0, 10, 2, 2000, 1, 1, 1); line_len = 20;            send_line();
    make_date(0, 10, 2, 2000, 1, 1, 1); line_len = 1;             send_line();
    make_date(0, 10, 2, 2000, 1, 1, 1);
    line_buf[29] = CHAR_G;
    line_buf[30] = CHAR_T;
    line_len = 31;
    send_line();
  endtask

  initial begin
    int sent;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    send_idle     = 13;
    recv_idle     = 84;
    hold_seq      = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    run_directed();
    wait_all_results();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 13 : (phase == 1) ? 84 : 0;
      recv_idle = (phase == 0) ? 84 : (phase == 1) ? 13 : 0;
      // With no idling, a long receiver hold-off makes the input stall.
      if (phase == 2) hold_seq = hold_seq + 1;
      sent = 0;
      while (sent < RANDOM_BYTES / 3) begin
        make_random_line();
        send_line();
        sent += line_len;
      end
      wait_all_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/hdp_pkg.sv
hdl/hdp_front.sv
hdl/hdp_mul.sv
hdl/hdp_seq.sv
hdl/http_date_parser.sv
bench/hdp_epoch_checker.sv
bench/tb.sv
